/* hw/rtl/sql_batch_statement_splitter_core_assert.svh */
// assertion macros for the statement splitter
`ifndef SQL_BATCH_STATEMENT_SPLITTER_CORE_ASSERT_SVH
`define SQL_BATCH_STATEMENT_SPLITTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// clocked assertion with explicit clock and reset
`define SBS_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// assertion on the block clock and reset
`define SBS_ASSERT(label, prop, msg) \
    `SBS_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`else

`define SBS_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define SBS_ASSERT(label, prop, msg)

`endif

`endif

/* hw/rtl/sbs_pkg.sv */
// shared types, constants and keyword helpers for the statement splitter
package sbs_pkg;

    localparam int WinDepth = 26;
    localparam int FillW    = 5;
    localparam int KwBits   = 8 * (WinDepth + 1);

    localparam logic [7:0] ChQuote = 8'h27;
    localparam logic [7:0] ChSemi  = 8'h3B;
    localparam logic [7:0] ChSlash = 8'h2F;
    localparam logic [7:0] ChCr    = 8'h0D;
    localparam logic [7:0] ChLf    = 8'h0A;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChTab   = 8'h09;

    // keywords, right aligned: last letter in the low byte
    localparam logic [KwBits-1:0] KwCf   = KwBits'("CREATE FUNCTION");
    localparam logic [KwBits-1:0] KwCorf = KwBits'("CREATE OR REPLACE FUNCTION");
    localparam logic [KwBits-1:0] KwCp   = KwBits'("CREATE PROCEDURE");
    localparam logic [KwBits-1:0] KwCorp = KwBits'("CREATE OR REPLACE PROCEDURE");
    localparam logic [KwBits-1:0] KwEnd  = KwBits'("END");

    typedef logic [WinDepth-1:0][7:0] t_window;

    typedef struct packed {
        logic create_hit;
        logic end_hit;
    } t_kw_hits;

    typedef struct packed {
        logic push;
        logic clear;
    } t_win_ctl;

    typedef struct packed {
        logic skip_pending;
    } t_status;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_kept;
        logic       statement_end;
        logic       statement_blank;
    } t_result;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h61:8'h7A]}) begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {ChSpace, ChTab, ChCr, ChLf};
    endfunction

    // keyword of klen letters ends at b with the window holding the earlier ones
    function automatic logic kw_hit(input logic [KwBits-1:0] kw, input int klen,
                                    input t_window win, input logic [FillW-1:0] fill,
                                    input logic [7:0] b);
        logic ok;
        ok = (fill >= FillW'(klen - 1)) && (upcase(b) == kw[7:0]);
        for (int i = 0; i < WinDepth; i++) begin
            if (i + 1 < klen) begin
                if (upcase(win[i]) != kw[8*(i+1) +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

endpackage

/* hw/rtl/sbs_window.sv */
// trailing byte window and parallel keyword compare
module sbs_window
    import sbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_text_byte,
    input  t_win_ctl   i_ctl,
    output t_kw_hits   o_hits
);

    t_window          r_win;
    t_window          n_win;
    logic [FillW-1:0] r_fill;
    logic [FillW-1:0] n_fill;

    always_comb begin
        n_win  = r_win;
        n_fill = r_fill;
        if (i_ctl.clear) begin
            n_fill = '0;
        end else if (i_ctl.push) begin
            n_win = {r_win[WinDepth-2:0], i_text_byte};
            if (r_fill < FillW'(WinDepth)) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    // entries beyond the fill count are never compared, so no clear needed
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    assign o_hits.create_hit = kw_hit(KwCf,   15, r_win, r_fill, i_text_byte)
                             | kw_hit(KwCorf, 26, r_win, r_fill, i_text_byte)
                             | kw_hit(KwCp,   16, r_win, r_fill, i_text_byte)
                             | kw_hit(KwCorp, 27, r_win, r_fill, i_text_byte);
    assign o_hits.end_hit    = kw_hit(KwEnd,  3,  r_win, r_fill, i_text_byte);

endmodule

/* hw/rtl/sbs_ctrl.sv */
// quote, procedure and terminator tracking; forms one result per byte
module sbs_ctrl
    import sbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_text_byte,
    input  logic       i_batch_last,
    input  t_kw_hits   i_hits,
    output t_result    o_result,
    output t_win_ctl   o_win_ctl,
    output t_status    o_status
);

    logic r_quote, n_quote;
    logic r_pm, n_pm;
    logic r_pe, n_pe;
    logic r_skip, n_skip;
    logic r_nb, n_nb;

    always_comb begin
        logic       term;
        logic [7:0] ob;
        logic       q;
        logic       pm;
        logic       pe;
        logic       nb;

        n_quote   = r_quote;
        n_pm      = r_pm;
        n_pe      = r_pe;
        n_skip    = r_skip;
        n_nb      = r_nb;
        o_result  = '0;
        o_win_ctl = '0;
        term      = 1'b0;
        ob        = i_text_byte;
        q         = r_quote;
        pm        = r_pm;
        pe        = r_pe;
        nb        = r_nb;

        if (i_accept) begin
            if (r_skip) begin
                n_skip = 1'b0;
                if (i_batch_last) begin
                    n_quote         = 1'b0;
                    n_pm            = 1'b0;
                    n_pe            = 1'b0;
                    n_nb            = 1'b0;
                    o_win_ctl.clear = 1'b1;
                end
            end else begin
                if (r_quote) begin
                    if (i_text_byte == ChQuote) begin
                        q = 1'b0;
                    end
                end else if (i_text_byte == ChQuote) begin
                    q = 1'b1;
                end else if (i_text_byte == ChSemi && !r_pm && !r_pe) begin
                    term = 1'b1;
                end else if (i_text_byte == ChSlash && r_pe) begin
                    pe   = 1'b0;
                    term = 1'b1;
                end else begin
                    if (i_hits.create_hit) begin
                        pm = 1'b1;
                    end
                    if (pm && i_hits.end_hit) begin
                        pm = 1'b0;
                        pe = 1'b1;
                    end
                    if (i_text_byte == ChCr || i_text_byte == ChLf) begin
                        ob = ChSpace;
                    end
                end

                if (term) begin
                    o_result.statement_end   = 1'b1;
                    o_result.statement_blank = !r_nb;
                    n_quote         = 1'b0;
                    n_pm            = 1'b0;
                    n_pe            = 1'b0;
                    n_nb            = 1'b0;
                    n_skip          = !i_batch_last;
                    o_win_ctl.clear = 1'b1;
                end else begin
                    nb                 = r_nb | !is_blank(i_text_byte);
                    o_result.out_byte  = ob;
                    o_result.byte_kept = 1'b1;
                    o_win_ctl.push     = 1'b1;
                    n_quote            = q;
                    n_pm               = pm;
                    n_pe               = pe;
                    n_nb               = nb;
                    if (i_batch_last) begin
                        o_result.statement_end   = 1'b1;
                        o_result.statement_blank = !nb;
                        n_quote         = 1'b0;
                        n_pm            = 1'b0;
                        n_pe            = 1'b0;
                        n_nb            = 1'b0;
                        o_win_ctl.clear = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote <= 1'b0;
            r_pm    <= 1'b0;
            r_pe    <= 1'b0;
            r_skip  <= 1'b0;
            r_nb    <= 1'b0;
        end else begin
            r_quote <= n_quote;
            r_pm    <= n_pm;
            r_pe    <= n_pe;
            r_skip  <= n_skip;
            r_nb    <= n_nb;
        end
    end

    assign o_status.skip_pending = r_skip;

endmodule

/* hw/rtl/sbs_out_skid.sv */
// result register with a skid entry behind it
module sbs_out_skid
    import sbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main, n_main;
    t_result r_skid, n_skid;
    logic    pop;

    assign pop = r_main_valid && i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (pop) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_main_valid || pop) begin
                n_main       = i_result;
                n_main_valid = 1'b1;
            end else begin
                n_skid       = i_result;
                n_skid_valid = 1'b1;
            end
        end else if (pop) begin
            n_main_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    assign o_ready  = !r_skid_valid;
    assign o_valid  = r_main_valid;
    assign o_result = r_main;

endmodule

/* hw/rtl/sql_batch_statement_splitter_core.sv */
// top level of the sql batch statement splitter
`include "sql_batch_statement_splitter_core_assert.svh"

// sql batch statement splitter: takes one byte of batch text per request and
// returns exactly one result request for it, in order. the byte is examined
// in the cycle it is accepted, against a 26-byte trailing window of the
// statement's raw bytes, so the block sustains one byte per clock unless the
// output stalls. the result register has a skid entry behind it, so input
// ready depends only on that entry being free and never combinationally on
// output ready. quotes ('...') are tracked; outside them cr and lf come out
// as space. create [or replace] function/procedure (any case) puts the
// statement in procedure mode, a following end arms '/' as terminator;
// otherwise ';' ends the statement. a terminator is not kept and the byte
// after it is dropped. statement_end also fires on the final byte of a
// batch when that byte is kept. statement_blank flags a statement holding
// only space, tab, cr or lf.
module sql_batch_statement_splitter_core
    import sbs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_text_byte,
    input  logic       i_batch_last,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_byte_kept,
    output logic       o_statement_end,
    output logic       o_statement_blank
);

    logic     in_accept;
    t_kw_hits hits;
    t_win_ctl win_ctl;
    t_status  status;
    t_result  result;
    t_result  out_result;

    // a byte is taken whenever the skid entry is free
    assign in_accept = i_in_valid && o_in_ready;

    // keyword window: shifts in every kept byte, cleared at statement end
    sbs_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_text_byte (i_text_byte),
        .i_ctl       (win_ctl),
        .o_hits      (hits)
    );

    // statement state and per-byte result
    sbs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_text_byte  (i_text_byte),
        .i_batch_last (i_batch_last),
        .i_hits       (hits),
        .o_result     (result),
        .o_win_ctl    (win_ctl),
        .o_status     (status)
    );

    // result register and skid entry
    sbs_out_skid u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_result (result),
        .o_ready  (o_in_ready),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_out_byte        = out_result.out_byte;
    assign o_byte_kept       = out_result.byte_kept;
    assign o_statement_end   = out_result.statement_end;
    assign o_statement_blank = out_result.statement_blank;

    // stalled input means a full skid, which needs a held result in front
    `SBS_ASSERT(a_stall_has_result, !o_in_ready |-> o_out_valid, "input stalled with no result")
    // a terminator mid-batch must drop the following byte
    `SBS_ASSERT(a_term_sets_skip, (in_accept && result.statement_end && !i_batch_last) |=> status.skip_pending, "terminator did not arm skip")
    // a dropped byte is neither kept nor a statement end
    `SBS_ASSERT(a_skip_drops, (in_accept && status.skip_pending) |-> (!result.byte_kept && !result.statement_end), "skipped byte leaked")
    // blank flag only at a statement end
    `SBS_ASSERT(a_blank_at_end, result.statement_blank |-> result.statement_end, "blank flag without end")

endmodule

/* tb/sv/tb_sql_batch_statement_splitter_core.sv */
// self-checking testbench for the sql batch statement splitter core
`timescale 1ns / 100ps

// byte stream test: directed corner bytes first, then random statements built as
// plain, procedure, blank, quoted and noise chunks with random batch ends. every
// accepted byte goes through a local model of the splitter and the one result it
// causes is queued; the monitor checks each returned result field by field
module tb_sql_batch_statement_splitter_core;
    import sbs_pkg::*;

    localparam int RandomBytes = 720;
    localparam int CycleLimit  = 200000;
    localparam int HoldAfter   = 250;   // requests accepted before the long stall
    localparam int HoldCycles  = 150;
    localparam int DrainCycles = 16;

    typedef struct {
        logic [7:0] text;
        logic       last;
    } t_text_req;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [7:0] i_text_byte = 8'h00;
    logic       i_batch_last = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [7:0] o_out_byte;
    logic       o_byte_kept;
    logic       o_statement_end;
    logic       o_statement_blank;

    t_text_req pending_bytes[$];
    t_result   expected_results[$];

    int cyc = 0;
    int errors = 0;
    int accepted_bytes = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    // splitter model state
    logic       quote_open = 1'b0;
    logic       proc_body = 1'b0;
    logic       end_armed = 1'b0;
    logic       drop_next = 1'b0;
    logic       saw_text = 1'b0;
    logic [7:0] tail [WinDepth];
    int         tail_fill = 0;

    sql_batch_statement_splitter_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_text_byte      (i_text_byte),
        .i_batch_last     (i_batch_last),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_byte       (o_out_byte),
        .o_byte_kept      (o_byte_kept),
        .o_statement_end  (o_statement_end),
        .o_statement_blank(o_statement_blank)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // splitter model
    // ------------------------------------------------------------------

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        if (c >= "a" && c <= "z") begin
            return c - 8'd32;
        end
        return c;
    endfunction

    // keyword ends on byte b, its earlier letters newest first in the tail
    function automatic logic tail_matches(input string kw, input logic [7:0] b);
        int   n;
        logic ok;
        n = kw.len();
        if (n - 1 > tail_fill) begin
            return 1'b0;
        end
        ok = (to_upper(b) == kw[n-1]);
        for (int i = 0; i + 1 < n; i++) begin
            if (to_upper(tail[i]) != kw[n-2-i]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    task automatic clear_statement();
        quote_open = 1'b0;
        proc_body  = 1'b0;
        end_armed  = 1'b0;
        saw_text   = 1'b0;
        tail_fill  = 0;
        for (int i = 0; i < WinDepth; i++) begin
            tail[i] = 8'h00;
        end
    endtask

    // works out the result for one accepted byte and queues it
    task automatic split_byte(input logic [7:0] b, input logic last);
        t_result    r;
        logic       term;
        logic [7:0] shown;
        r     = '0;
        term  = 1'b0;
        shown = b;
        if (drop_next) begin
            // byte after a terminator: dropped, belongs to no statement
            drop_next = 1'b0;
            if (last) begin
                clear_statement();
            end
        end else begin
            if (quote_open) begin
                if (b == ChQuote) begin
                    quote_open = 1'b0;
                end
            end else if (b == ChQuote) begin
                quote_open = 1'b1;
            end else if (b == ChSemi && !proc_body && !end_armed) begin
                term = 1'b1;
            end else if (b == ChSlash && end_armed) begin
                end_armed = 1'b0;
                term      = 1'b1;
            end else begin
                if (tail_matches("CREATE FUNCTION", b) ||
                    tail_matches("CREATE OR REPLACE FUNCTION", b) ||
                    tail_matches("CREATE PROCEDURE", b) ||
                    tail_matches("CREATE OR REPLACE PROCEDURE", b)) begin
                    proc_body = 1'b1;
                end
                if (proc_body && tail_matches("END", b)) begin
                    proc_body = 1'b0;
                    end_armed = 1'b1;
                end
                if (b == ChCr || b == ChLf) begin
                    shown = ChSpace;
                end
            end

            if (term) begin
                r.statement_end   = 1'b1;
                r.statement_blank = !saw_text;
                clear_statement();
                drop_next = !last;
            end else begin
                r.out_byte  = shown;
                r.byte_kept = 1'b1;
                if (b != ChSpace && b != ChTab && b != ChCr && b != ChLf) begin
                    saw_text = 1'b1;
                end
                for (int i = WinDepth - 1; i > 0; i--) begin
                    tail[i] = tail[i-1];
                end
                tail[0] = b;
                if (tail_fill < WinDepth) begin
                    tail_fill++;
                end
                if (last) begin
                    // batch end on a kept byte closes the statement with it
                    r.statement_end   = 1'b1;
                    r.statement_blank = !saw_text;
                    clear_statement();
                end
            end
        end
        expected_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------

    task automatic queue_byte(input logic [7:0] b, input logic last);
        t_text_req t;
        t.text = b;
        t.last = last;
        pending_bytes.push_back(t);
    endtask

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
            return c | 8'h20;
        end
        return c;
    endfunction

    // a keyword phrase in random case; a space may turn into cr or lf
    task automatic queue_word(input string s, input bit break_it);
        logic [7:0] c;
        for (int i = 0; i < s.len(); i++) begin
            c = s[i];
            if (c == ChSpace && break_it && $urandom_range(0, 2) == 0) begin
                c = $urandom_range(0, 1) ? ChCr : ChLf;
            end
            queue_byte(mix_case(c), 1'b0);
        end
    endtask

    function automatic logic [7:0] filler_char();
        case ($urandom_range(0, 11))
            0, 1:    return ChSpace;
            2: begin
                case ($urandom_range(0, 2))
                    0:       return ChTab;
                    1:       return ChCr;
                    default: return ChLf;
                endcase
            end
            3:       return 8'h30 + 8'($urandom_range(0, 9));
            4:       return ($urandom_range(0, 1) == 1) ? ChSlash : 8'h28 + 8'($urandom_range(0, 4));
            5:       return 8'($urandom_range(128, 255));
            default: return mix_case(8'h41 + 8'($urandom_range(0, 25)));
        endcase
    endfunction

    task automatic queue_filler(input int n);
        for (int i = 0; i < n; i++) begin
            queue_byte(filler_char(), 1'b0);
        end
    endtask

    // quoted string with terminators and line breaks hidden inside
    task automatic queue_quoted();
        int n;
        n = $urandom_range(0, 6);
        queue_byte(ChQuote, 1'b0);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0:       queue_byte(ChSemi, 1'b0);
                1:       queue_byte(ChLf, 1'b0);
                default: queue_byte(filler_char(), 1'b0);
            endcase
        end
        queue_byte(ChQuote, 1'b0);
    endtask

    // terminator, then usually the dropped byte after it
    task automatic queue_close(input logic [7:0] term);
        if ($urandom_range(0, 9) == 0) begin
            queue_byte(term, 1'b1);
        end else begin
            queue_byte(term, 1'b0);
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic queue_procedure();
        bit broken;
        broken = ($urandom_range(0, 7) == 0);
        queue_filler($urandom_range(0, 2));
        case ($urandom_range(0, 3))
            0:       queue_word("CREATE FUNCTION ", broken);
            1:       queue_word("CREATE OR REPLACE FUNCTION ", broken);
            2:       queue_word("CREATE PROCEDURE ", broken);
            default: queue_word("CREATE OR REPLACE PROCEDURE ", broken);
        endcase
        for (int i = $urandom_range(1, 4); i > 0; i--) begin
            queue_filler($urandom_range(0, 6));
            case ($urandom_range(0, 2))
                0:       queue_byte(ChSemi, 1'b0);    // kept inside the body unless the keyword was broken
                1:       queue_quoted();
                default: queue_byte(ChSpace, 1'b0);
            endcase
        end
        queue_word("END", 1'b0);
        if ($urandom_range(0, 2) == 0) begin
            queue_byte(ChSemi, 1'b0);
        end
        queue_byte(($urandom_range(0, 1) == 1) ? ChLf : ChSpace, 1'b0);
        queue_close(ChSlash);
    endtask

    task automatic build_stimulus();
        // corner bytes, quotes, line breaks, bare slash, blank statement
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(ChCr, 1'b0);
        queue_byte(ChLf, 1'b0);
        queue_byte(ChQuote, 1'b0);
        queue_byte(ChLf, 1'b0);
        queue_byte(ChSemi, 1'b0);
        queue_byte(ChQuote, 1'b0);
        queue_byte(ChSlash, 1'b0);
        queue_byte(ChSemi, 1'b0);
        queue_byte("A", 1'b0);
        queue_byte(ChSpace, 1'b0);
        queue_byte(ChTab, 1'b0);
        queue_byte(ChSemi, 1'b0);
        queue_byte("Q", 1'b1);         // batch ends on the dropped byte
        queue_byte("x", 1'b1);         // one-byte batch, kept and closed
        queue_byte(ChSemi, 1'b1);      // terminator is the last byte

        while (pending_bytes.size() < RandomBytes) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    queue_filler($urandom_range(0, 14));
                    if ($urandom_range(0, 3) == 0) begin
                        queue_word(" END ", 1'b0);
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        queue_quoted();
                    end
                    queue_close(ChSemi);
                end
                4, 5, 6: queue_procedure();
                7: begin
                    for (int i = $urandom_range(1, 8); i > 0; i--) begin
                        queue_byte(8'($urandom_range(0, 255)), 1'b0);
                    end
                end
                8: begin
                    for (int i = $urandom_range(0, 4); i > 0; i--) begin
                        queue_byte(($urandom_range(0, 1) == 1) ? ChSpace : ChTab, 1'b0);
                    end
                    queue_close(ChSemi);
                end
                default: begin
                    queue_filler($urandom_range(1, 10));
                    pending_bytes[pending_bytes.size()-1].last = 1'b1;
                end
            endcase
            if ($urandom_range(0, 5) == 0) begin
                pending_bytes[pending_bytes.size()-1].last = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // handshake sides
    // ------------------------------------------------------------------

    // stretches of cycles in which neither side pauses
    function automatic bit take_break();
        if ((cyc % 1024) >= 800) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 33;
    endfunction

    // sender: offers the oldest pending byte, holds it until taken
    always @(posedge i_clk) begin
        bit offering;
        offering = 1'b0;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            offering = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                split_byte(pending_bytes[0].text, pending_bytes[0].last);
                void'(pending_bytes.pop_front());
                accepted_bytes++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (pending_bytes.size() > 0 && !take_break()) begin
                    i_in_valid   <= 1'b1;
                    i_text_byte  <= pending_bytes[0].text;
                    i_batch_last <= pending_bytes[0].last;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (!hold_done && accepted_bytes >= HoldAfter) begin
            hold_done   <= 1'b1;
            hold_left   <= HoldCycles;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !take_break();
        end
    end

    // monitor: each returned result against the oldest expectation
    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            errors++;
            if (errors <= 10) begin
                $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
                         field, cyc, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result at cycle %0d: byte %0h", cyc, o_out_byte);
                end
            end else begin
                want = expected_results.pop_front();
                check_field("out_byte", want.out_byte, o_out_byte);
                check_field("byte_kept", want.byte_kept, o_byte_kept);
                check_field("statement_end", want.statement_end, o_statement_end);
                check_field("statement_blank", want.statement_blank, o_statement_blank);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        clear_statement();
        build_stimulus();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_bytes.size() != 0 || i_in_valid || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DrainCycles) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/sbs_pkg.sv
hw/rtl/sbs_window.sv
hw/rtl/sbs_ctrl.sv
hw/rtl/sbs_out_skid.sv
hw/rtl/sql_batch_statement_splitter_core.sv
tb/sv/tb_sql_batch_statement_splitter_core.sv
